// ----- hdl/vp_pkg.sv -----
// Shared types and constants for the vector projection block.
// Used by every file under hdl except vp_ram; depends on nothing.
package vp_pkg;

    localparam int MAX_LEN_DEF    = 64;
    localparam int ELEM_WIDTH_DEF = 16;

    // Q38.0 dot-product accumulators and the Q16.16 ratio
    localparam int ACC_W   = 38;
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = 32;

    // Length field of a job; covers the largest vector length of 64
    localparam int N_W = 7;

    // Vectors that may be loaded or pending at once (one per u-store bank)
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [ACC_W-1:0] uv;
        logic signed [ACC_W-1:0] uu;
        logic [N_W-1:0]          n;
        logic                    bank;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hdl/vp_pair_if.sv -----
// Input channel of the vector projection block: one (u, v) element pair.
// Depends on vp_pkg for the default element width.
interface vp_pair_if #(
    parameter int ELEM_WIDTH = vp_pkg::ELEM_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] u_elem;
    logic signed [ELEM_WIDTH-1:0] v_elem;
    logic                         last_elem;

    modport source (output valid, output u_elem, output v_elem, output last_elem,
                    input ready);
    modport sink   (input valid, input u_elem, input v_elem, input last_elem,
                    output ready);
endinterface

// ----- hdl/vp_proj_if.sv -----
// Output channel of the vector projection block: one projected element.
// Depends on vp_pkg for the default element width.
interface vp_proj_if #(
    parameter int ELEM_WIDTH = vp_pkg::ELEM_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] proj_elem;
    logic                         last_out;
    logic                         zero_divisor;

    modport source (output valid, output proj_elem, output last_out, output zero_divisor,
                    input ready);
    modport sink   (input valid, input proj_elem, input last_out, input zero_divisor,
                    output ready);
endinterface

// ----- hdl/vp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module vp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, holds its data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/vp_front.sv -----
// Front end: accepts element pairs, stores u, accumulates u.v and u.u,
// and pushes one job per vector. Depends on vp_pkg and vp_pair_if.
module vp_front #(
    parameter int MAX_LEN    = vp_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = vp_pkg::ELEM_WIDTH_DEF,
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int AW        = IDX_W + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    vp_pair_if.sink               pairs,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [ELEM_WIDTH-1:0] ram_wdata,
    output logic                  job_push,
    output vp_pkg::job_t          job,
    input  vp_pkg::q_status_t     q_st,
    input  logic                  release_job
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PW     = 2 * ELEM_WIDTH;
    localparam int XW     = (PW > vp_pkg::ACC_W) ? PW : vp_pkg::ACC_W;
    localparam int OPEN_W = $clog2(vp_pkg::QUEUE_DEPTH + 1);

    logic accept;
    logic keep;

    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              bank_reg,   bank_next;
    logic [OPEN_W-1:0] open_reg,   open_next;

    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic [CNT_W-1:0]             s1_n_reg;
    logic                         s1_bank_reg;
    logic signed [ELEM_WIDTH-1:0] s1_u_reg;
    logic signed [ELEM_WIDTH-1:0] s1_v_reg;

    logic                             s2_valid_reg;
    logic                             s2_last_reg;
    logic [CNT_W-1:0]                 s2_n_reg;
    logic                             s2_bank_reg;
    logic signed [vp_pkg::ACC_W-1:0]  s2_puv_reg;
    logic signed [vp_pkg::ACC_W-1:0]  s2_puu_reg;

    logic signed [vp_pkg::ACC_W-1:0]  acc_uv_reg, acc_uv_next;
    logic signed [vp_pkg::ACC_W-1:0]  acc_uu_reg, acc_uu_next;

    logic signed [PW-1:0]             puv_full;
    logic signed [PW-1:0]             puu_full;
    logic signed [XW-1:0]             puv_ext;
    logic signed [XW-1:0]             puu_ext;
    logic signed [vp_pkg::ACC_W-1:0]  sum_uv;
    logic signed [vp_pkg::ACC_W-1:0]  sum_uu;

    // Hold off new pairs while both u-store banks are taken
    assign pairs.ready = (open_reg < OPEN_W'(vp_pkg::QUEUE_DEPTH));
    assign accept      = pairs.valid && pairs.ready;
    assign keep        = (count_reg < CNT_W'(MAX_LEN));

    // Store u in the bank of the vector being loaded
    assign ram_we    = accept && keep;
    assign ram_waddr = {bank_reg, count_reg[IDX_W-1:0]};
    assign ram_wdata = pairs.u_elem;

    // Element count, bank select and open-job count
    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (pairs.last_elem)
            begin
                count_next = '0;
                bank_next  = ~bank_reg;
            end
            else
            begin
                count_next = count_reg + CNT_W'(keep);
            end
        end
        open_next = open_reg + OPEN_W'(accept && pairs.last_elem) - OPEN_W'(release_job);
    end

    // Products, sign-extended or wrapped to accumulator width
    assign puv_full = s1_u_reg * s1_v_reg;
    assign puu_full = s1_u_reg * s1_u_reg;
    assign puv_ext  = XW'(puv_full);
    assign puu_ext  = XW'(puu_full);

    // Accumulate; the last pair closes the vector and clears the sums
    assign sum_uv = acc_uv_reg + s2_puv_reg;
    assign sum_uu = acc_uu_reg + s2_puu_reg;

    always_comb
    begin
        acc_uv_next = acc_uv_reg;
        acc_uu_next = acc_uu_reg;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                acc_uv_next = '0;
                acc_uu_next = '0;
            end
            else
            begin
                acc_uv_next = sum_uv;
                acc_uu_next = sum_uu;
            end
        end
    end

    assign job_push = s2_valid_reg && s2_last_reg;
    assign job.uv   = sum_uv;
    assign job.uu   = sum_uu;
    assign job.n    = vp_pkg::N_W'(s2_n_reg);
    assign job.bank = s2_bank_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            bank_reg     <= 1'b0;
            open_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_uv_reg   <= '0;
            acc_uu_reg   <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            bank_reg     <= bank_next;
            open_reg     <= open_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            acc_uv_reg   <= acc_uv_next;
            acc_uu_reg   <= acc_uu_next;
        end
    end

    // Pipeline payload; a dropped pair enters as zeros
    always_ff @(posedge clk)
    begin
        s1_u_reg    <= keep ? pairs.u_elem : '0;
        s1_v_reg    <= keep ? pairs.v_elem : '0;
        s1_last_reg <= pairs.last_elem;
        s1_n_reg    <= count_reg + CNT_W'(keep);
        s1_bank_reg <= bank_reg;
        s2_puv_reg  <= puv_ext[vp_pkg::ACC_W-1:0];
        s2_puu_reg  <= puu_ext[vp_pkg::ACC_W-1:0];
        s2_last_reg <= s1_last_reg;
        s2_n_reg    <= s1_n_reg;
        s2_bank_reg <= s1_bank_reg;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_st.full)
        else $error("job pushed into a full queue");

    a_release_open: assert property (@(posedge clk) disable iff (!rst_n)
        release_job |-> (open_reg != '0))
        else $error("bank released with no open job");

endmodule

// ----- hdl/vp_queue.sv -----
// Short job queue between front and back end.
// Depends on vp_pkg for the job type and depth.
module vp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vp_pkg::job_t      din,
    input  logic              pop,
    output vp_pkg::job_t      dout,
    output vp_pkg::q_status_t st
);

    localparam int DEPTH = vp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vp_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    assign st.full  = (cnt_reg == CNT_W'(DEPTH));
    assign st.empty = (cnt_reg == '0);
    assign dout     = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- hdl/vp_div.sv -----
// Restoring divider, one quotient bit per cycle: (uv << 16) / uu,
// truncated toward zero and saturated to 32 bits. Depends on vp_pkg.
module vp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vp_pkg::ACC_W-1:0]   uv,
    input  logic signed [vp_pkg::ACC_W-1:0]   uu,
    output logic                              done,
    output logic signed [vp_pkg::RATIO_W-1:0] ratio
);

    localparam int AW     = vp_pkg::ACC_W;
    localparam int RW     = vp_pkg::RATIO_W;
    localparam int NQ_W   = vp_pkg::ACC_W + vp_pkg::FRAC_W;
    localparam int STEP_W = $clog2(NQ_W + 1);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [AW-1:0]     rem_reg;
    logic [AW-1:0]     den_reg;
    logic [NQ_W-1:0]   nq_reg;
    logic signed [RW-1:0] ratio_reg;

    logic [AW-1:0]   uv_mag;
    logic [AW-1:0]   uu_mag;
    logic [AW:0]     trial;
    logic [AW:0]     diff;
    logic            ge;
    logic            sat_pos;
    logic            sat_neg;
    logic [RW-1:0]   q_low;

    assign uv_mag = uv[AW-1] ? (~uv + 1'b1) : uv;
    assign uu_mag = uu[AW-1] ? (~uu + 1'b1) : uu;

    // One restoring step: shift in the next numerator bit, try the subtract
    assign trial = {rem_reg, nq_reg[NQ_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    // Saturation of the quotient magnitude
    assign q_low   = nq_reg[RW-1:0];
    assign sat_pos = (nq_reg[NQ_W-1:RW-1] != '0);
    assign sat_neg = (nq_reg[NQ_W-1:RW] != '0) || (nq_reg[RW-1] && (nq_reg[RW-2:0] != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NQ_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, iterate, then sign and saturate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= {uv_mag, {vp_pkg::FRAC_W{1'b0}}};
            den_reg <= uu_mag;
            rem_reg <= '0;
            neg_reg <= uv[AW-1] ^ uu[AW-1];
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[NQ_W-2:0], ge};
            rem_reg <= ge ? diff[AW-1:0] : trial[AW-1:0];
        end
        if (fin_reg)
        begin
            if (neg_reg)
            begin
                ratio_reg <= sat_neg ? {1'b1, {(RW-1){1'b0}}} : $signed(~q_low + 1'b1);
            end
            else
            begin
                ratio_reg <= sat_pos ? {1'b0, {(RW-1){1'b1}}} : $signed(q_low);
            end
        end
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;

endmodule

// ----- hdl/vp_back.sv -----
// Back end: takes one job at a time, divides, then streams the stored u
// elements through read, multiply and round stages. Depends on vp_pkg,
// vp_proj_if and vp_div.
module vp_back #(
    parameter int MAX_LEN    = vp_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = vp_pkg::ELEM_WIDTH_DEF,
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int AW        = IDX_W + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vp_pkg::job_t                 job,
    input  vp_pkg::q_status_t            q_st,
    output logic                         pop,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic signed [ELEM_WIDTH-1:0] ram_rdata,
    output logic                         release_job,
    vp_proj_if.source                    proj
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int RW    = vp_pkg::RATIO_W;
    localparam int PRW   = ELEM_WIDTH + RW;
    localparam int SW    = PRW - vp_pkg::FRAC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_last_reg;
    logic             bank_reg;
    logic             zero_reg;
    logic signed [RW-1:0] ratio_reg;

    logic                         a_valid_reg;
    logic                         a_last_reg;
    logic                         b_valid_reg;
    logic                         b_last_reg;
    logic signed [PRW-1:0]        prod_reg;
    logic                         out_valid_reg;
    logic                         out_last_reg;
    logic                         out_zero_reg;
    logic signed [ELEM_WIDTH-1:0] out_proj_reg;

    logic                         job_zero;
    logic                         div_start;
    logic                         div_done;
    logic signed [RW-1:0]         div_ratio;
    logic                         adv;
    logic                         issue;
    logic                         k_is_last;
    logic signed [PRW-1:0]        prod_full;
    logic signed [SW-1:0]         shifted;
    logic [SW-ELEM_WIDTH:0]       hi_bits;
    logic                         fits;
    logic signed [ELEM_WIDTH-1:0] proj_sat;

    // Take a job only once the element stages have drained
    assign pop       = (state_reg == ST_IDLE) && !q_st.empty && !a_valid_reg && !b_valid_reg;
    assign job_zero  = (job.uu == '0);
    assign div_start = pop && !job_zero;

    vp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .uv    (job.uv),
        .uu    (job.uu),
        .done  (div_done),
        .ratio (div_ratio)
    );

    // Whole element pipeline moves when the output register can take a value
    assign adv         = !out_valid_reg || proj.ready;
    assign issue       = (state_reg == ST_EMIT) && adv;
    assign k_is_last   = (k_reg == k_last_reg);
    assign release_job = issue && k_is_last;
    assign ram_re      = issue;
    assign ram_raddr   = {bank_reg, k_reg[IDX_W-1:0]};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = job_zero ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (release_job)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Multiply, floor-shift by 16, saturate to the element range
    assign prod_full = ram_rdata * ratio_reg;
    assign shifted   = prod_reg[PRW-1:vp_pkg::FRAC_W];
    assign hi_bits   = shifted[SW-1:ELEM_WIDTH-1];
    assign fits      = (&hi_bits) || !(|hi_bits);
    assign proj_sat  = fits ? shifted[ELEM_WIDTH-1:0]
                     : (shifted[SW-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ELEM_WIDTH-1){1'b1}}});

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (adv)
            begin
                a_valid_reg   <= issue;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // Job fields, ratio and element payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            k_last_reg <= CNT_W'(job.n) - 1'b1;
            bank_reg   <= job.bank;
            zero_reg   <= job_zero;
        end
        if (pop && job_zero)
        begin
            ratio_reg <= '0;
        end
        else if (div_done)
        begin
            ratio_reg <= div_ratio;
        end
        if (adv)
        begin
            a_last_reg   <= k_is_last;
            prod_reg     <= prod_full;
            b_last_reg   <= a_last_reg;
            out_proj_reg <= proj_sat;
            out_last_reg <= b_last_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign proj.valid        = out_valid_reg;
    assign proj.proj_elem    = out_proj_reg;
    assign proj.last_out     = out_last_reg;
    assign proj.zero_divisor = out_zero_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the division phase");

    a_div_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (!a_valid_reg && !b_valid_reg))
        else $error("ratio may change under elements still in flight");

endmodule

// ----- hdl/vector_projection_top.sv -----
// Top level of the vector projection block: front end, job queue, back end
// and the double-banked u store. Depends on vp_pkg, both channel interfaces,
// vp_ram, vp_front, vp_queue, vp_div and vp_back.
//
//   channel | dir | payload                               | handshake
//   --------+-----+---------------------------------------+-------------
//   pairs   | in  | u_elem, v_elem, last_elem             | valid/ready
//   proj    | out | proj_elem, last_out, zero_divisor     | valid/ready
//
// Pairs load at one per cycle while a bank is free; a vector's sums close once its last pair
// has passed the s1 and s2 registers. Each vector is then divided in the bit-serial divider
// (skipped when u.u is zero), then gives one result per cycle after a three-stage
// read/multiply/round pipe while the output is ready.
// The u store has two banks: one vector loads while the previous one is divided and emitted;
// pairs stall while two vectors are open. No clearing pass after reset.
// Output stalls freeze the element pipe only; loading continues until both banks are taken.
module vector_projection_top #(
    parameter int MAX_LEN    = vp_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = vp_pkg::ELEM_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vp_pair_if.sink    pairs,
    vp_proj_if.source  proj
);

    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW        = IDX_W + 1;
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ELEM_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    logic                  job_push;
    logic                  job_pop;
    logic                  release_job;
    vp_pkg::job_t          push_job;
    vp_pkg::job_t          head_job;
    vp_pkg::q_status_t     q_st;

    vp_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vp_front #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pairs       (pairs),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .job_push    (job_push),
        .job         (push_job),
        .q_st        (q_st),
        .release_job (release_job)
    );

    vp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (push_job),
        .pop   (job_pop),
        .dout  (head_job),
        .st    (q_st)
    );

    vp_back #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (head_job),
        .q_st        (q_st),
        .pop         (job_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   ($signed(ram_rdata)),
        .release_job (release_job),
        .proj        (proj)
    );

endmodule

// ----- sim/vp_proj_checker.sv -----
`timescale 1ns / 100ps
// Checker for vector_projection_top: watches the pair and projection channels,
// predicts every projected element and compares in order. Depends on vp_pkg,
// vp_pair_if and vp_proj_if.
module vp_proj_checker #(
    parameter int MAX_LEN    = vp_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = vp_pkg::ELEM_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    vp_pair_if   pairs,
    vp_proj_if   proj,
    output int   mismatches,
    output int   outstanding
);

    localparam longint ELEM_MAX  = (longint'(1) <<< (ELEM_WIDTH - 1)) - 1;
    localparam longint ELEM_MIN  = -ELEM_MAX - 1;
    localparam longint RATIO_MAX = (longint'(1) <<< (vp_pkg::RATIO_W - 1)) - 1;
    localparam longint RATIO_MIN = -RATIO_MAX - 1;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] elem;
        logic                  last;
        logic                  zero_div;
    } proj_elem_t;

    // Projected elements still owed by the block, oldest first
    proj_elem_t expected_proj[$];

    // Shadow of the vector being loaded
    logic signed [ELEM_WIDTH-1:0]    u_held [MAX_LEN];
    logic signed [vp_pkg::ACC_W-1:0] dot_uv;
    logic signed [vp_pkg::ACC_W-1:0] dot_uu;
    int                              held_count;

    function automatic longint clamp_range(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        proj_elem_t want;
        proj_elem_t item;
        bit         have;
        bit         zero_div;
        longint     ratio;
        longint     scaled;
        if (!rst_n)
        begin
            expected_proj.delete();
            dot_uv = '0;
            dot_uu = '0;
            held_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Match an output transaction against the oldest expected element
            if (proj.valid && proj.ready)
            begin
                have = (expected_proj.size() != 0);
                want = '0;
                if (have)
                    want = expected_proj.pop_front();
                if (!have || proj.proj_elem !== want.elem || proj.last_out !== want.last
                        || proj.zero_divisor !== want.zero_div)
                begin
                    if (mismatches < 10)
                        $display("%0t: projection mismatch%s: expected elem %0d last %0b zero %0b,",
                                 $time, have ? "" : " (nothing expected)",
                                 $signed(want.elem), want.last, want.zero_div,
                                 " got elem %0d last %0b zero %0b",
                                 proj.proj_elem, proj.last_out, proj.zero_divisor);
                    mismatches <= mismatches + 1;
                end
            end

            // Fold an input transaction into the sums; drop pairs beyond the store
            if (pairs.valid && pairs.ready)
            begin
                if (held_count < MAX_LEN)
                begin
                    u_held[held_count] = pairs.u_elem;
                    dot_uv = dot_uv + vp_pkg::ACC_W'(longint'(pairs.u_elem)
                                                     * longint'(pairs.v_elem));
                    dot_uu = dot_uu + vp_pkg::ACC_W'(longint'(pairs.u_elem)
                                                     * longint'(pairs.u_elem));
                    held_count++;
                end

                // Close the vector: ratio in Q16.16, then scale every held u element
                if (pairs.last_elem)
                begin
                    zero_div = (dot_uu == 0);
                    ratio = 0;
                    if (!zero_div)
                        ratio = clamp_range((longint'(dot_uv) <<< vp_pkg::FRAC_W)
                                            / longint'(dot_uu),
                                            RATIO_MIN, RATIO_MAX);
                    for (int k = 0; k < held_count; k++)
                    begin
                        scaled = 0;
                        if (!zero_div)
                            scaled = clamp_range((longint'(u_held[k]) * ratio)
                                                 >>> vp_pkg::FRAC_W,
                                                 ELEM_MIN, ELEM_MAX);
                        item.elem = ELEM_WIDTH'(scaled);
                        item.last = (k == held_count - 1);
                        item.zero_div = zero_div;
                        expected_proj.push_back(item);
                    end
                    dot_uv = '0;
                    dot_uu = '0;
                    held_count = 0;
                end
            end
            outstanding <= expected_proj.size();
        end
    end

endmodule

// ----- sim/tb_vector_projection_top.sv -----
`timescale 1ns / 100ps
// Testbench top for vector_projection_top: clock, reset, pair stimulus and
// output backpressure, with the verdict. Depends on vp_pkg, vp_pair_if,
// vp_proj_if, vp_proj_checker and the block itself.
module tb_vector_projection_top;

    localparam int     EW           = vp_pkg::ELEM_WIDTH_DEF;
    localparam int     MAXN         = vp_pkg::MAX_LEN_DEF;
    localparam int     RANDOM_PAIRS = 154;
    localparam int     DRAIN_CYCLES = 120;
    localparam longint TIMEOUT_NS   = 3_000_000;

    // Ways of filling a random vector
    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_NULL_U,
        FILL_ALIGNED,
        FILL_EXTREME
    } fill_t;

    logic clk;
    logic rst_n;
    logic pair_taken = 1'b0;
    bit   steady = 1'b0;
    int   mismatches;
    int   outstanding;

    vp_pair_if #(.ELEM_WIDTH(EW)) pairs ();
    vp_proj_if #(.ELEM_WIDTH(EW)) proj ();

    vector_projection_top #(.MAX_LEN(MAXN), .ELEM_WIDTH(EW)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pairs (pairs),
        .proj  (proj)
    );

    vp_proj_checker #(.MAX_LEN(MAXN), .ELEM_WIDTH(EW)) u_proj_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pairs       (pairs),
        .proj        (proj),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Record each input transaction so the driver can see it at the falling edge
    always @(posedge clk)
        pair_taken <= pairs.valid && pairs.ready;

    // Idle length: mostly none, some short, a few long; none in a steady stretch
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [EW-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return {1'b1, {(EW-1){1'b0}}};
            1:       return {1'b0, {(EW-1){1'b1}}};
            2:       return '1;
            3:       return EW'(1);
            default: return '0;
        endcase
    endfunction

    // Present one pair, hold it until taken, then idle for a while
    task automatic send_pair(input logic signed [EW-1:0] u, input logic signed [EW-1:0] v,
                             input logic last);
        int idle;
        pairs.valid     <= 1'b1;
        pairs.u_elem    <= u;
        pairs.v_elem    <= v;
        pairs.last_elem <= last;
        do @(negedge clk); while (!pair_taken);
        idle = idle_len();
        if (idle > 0)
        begin
            pairs.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
    endtask

    // Stall the output side at random
    initial
    begin
        int busy;
        int stall;
        proj.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            proj.ready <= 1'b1;
            busy = $urandom_range(1, 12);
            repeat (busy) @(negedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                proj.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int                   len;
        int                   sent;
        int                   scale;
        int                   full_at;
        int                   overlong_at;
        fill_t                fill;
        logic signed [EW-1:0] u;
        logic signed [EW-1:0] v;

        rst_n = 1'b0;
        pairs.valid = 1'b0;
        pairs.u_elem = '0;
        pairs.v_elem = '0;
        pairs.last_elem = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: unit ratio, extremes, ratio clamp, floor rounding
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(-16'sd1, 16'sh8000, 1'b1);
        send_pair(16'sd1, 16'sh8000, 1'b1);
        send_pair(16'sd3, -16'sd1, 1'b1);
        // Zero divisor, one and two elements
        send_pair(16'sd0, 16'sh7FFF, 1'b1);
        send_pair(16'sd0, 16'sh1234, 1'b0);
        send_pair(16'sd0, -16'sd5, 1'b1);
        // Projected element beyond Q16.0, saturated
        send_pair(16'sd1, 16'sh7FFF, 1'b0);
        send_pair(16'sd16, 16'sh7FFF, 1'b1);
        // Mixed signs at full scale
        send_pair(16'sh7FFF, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh00FF, 16'sh0100, 1'b1);
        // Alternating bit patterns
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);

        // Random vectors: mostly short, one full and one past the store length
        sent = 0;
        full_at = $urandom_range(1, 3);
        overlong_at = $urandom_range(5, 8);
        for (int vec = 0; sent < RANDOM_PAIRS || vec <= overlong_at; vec++)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if (vec == full_at)
                len = MAXN;
            else if (vec == overlong_at)
                len = MAXN + $urandom_range(1, 4);
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(7, 16);
            else
                len = $urandom_range(1, 6);
            fill = fill_t'($urandom_range(0, 4));
            scale = int'($urandom_range(0, 16)) - 8;
            for (int k = 0; k < len; k++)
            begin
                case (fill)
                    FILL_WIDE:
                    begin
                        u = EW'($urandom);
                        v = EW'($urandom);
                    end
                    FILL_NARROW:
                    begin
                        u = EW'(int'($urandom_range(0, 1023)) - 512);
                        v = EW'(int'($urandom_range(0, 1023)) - 512);
                    end
                    FILL_NULL_U:
                    begin
                        u = '0;
                        v = EW'($urandom);
                    end
                    FILL_ALIGNED:
                    begin
                        u = EW'(int'($urandom_range(0, 8191)) - 4096);
                        v = EW'(((int'(u) * scale) >>> 3) + int'($urandom_range(0, 15)) - 8);
                    end
                    default:
                    begin
                        u = extreme_value();
                        v = extreme_value();
                    end
                endcase
                send_pair(u, v, k == len - 1);
                sent++;
            end
        end
        steady = 1'b0;
        pairs.valid <= 1'b0;
        pairs.last_elem <= 1'b0;

        // Drain: wait for every owed element, then let the block settle
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("vector_projection_top test passed");
        else
            $display("vector_projection_top test failed");
        $finish;
    end

    // Hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("vector_projection_top test failed");
        $finish;
    end

endmodule
